// ===== sv/sgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared widths, codes and types for the stochastic grid contagion block.
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int GRID_SIDE_DEF   = 4;
    localparam int GROUP_COUNT_DEF = 4;

    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 4;
    localparam int ROLL_W      = 7;
    localparam int THR_W       = 7;
    localparam int MODE_W      = 2;
    localparam int GATES_W     = 16;
    localparam int GRP_OUT_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [THR_W-1:0]  SPREAD_RST  = 7'd10;
    localparam logic [THR_W-1:0]  RECOVER_RST = 7'd10;
    localparam logic [MODE_W-1:0] MODE_RST    = 2'd0;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_PRESS  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd2;

    // press modes
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIX    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GROUP  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

    // addressed cell plus previous state of its in-grid neighbors
    typedef struct packed {
        logic on;
        logic was_on;
        logic fixed;
        logic nb_up;
        logic nb_down;
        logic nb_left;
        logic nb_right;
    } cell_view_t;

    typedef struct packed {
        logic on;
        logic was_on;
        logic fixed;
    } cell_upd_t;

endpackage

// ===== sv/sgc_cell_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_cell_update
// Next state of one addressed cell for a press or a step beat.
// ----------------------------------------------------------------------------
module sgc_cell_update #(
    parameter int GROUP_COUNT = sgc_pkg::GROUP_COUNT_DEF,
    parameter int GTAG_W      = 2
) (
    input  logic [sgc_pkg::FUNC_W-1:0] func,
    input  logic [sgc_pkg::MODE_W-1:0] edit_mode,
    input  logic [sgc_pkg::THR_W-1:0]  spread_thr,
    input  logic [sgc_pkg::THR_W-1:0]  recover_thr,
    input  logic                       gate_high,
    input  logic [sgc_pkg::ROLL_W-1:0] roll_up,
    input  logic [sgc_pkg::ROLL_W-1:0] roll_down,
    input  logic [sgc_pkg::ROLL_W-1:0] roll_left,
    input  logic [sgc_pkg::ROLL_W-1:0] roll_right,
    input  logic [sgc_pkg::ROLL_W-1:0] roll_cure,
    input  sgc_pkg::cell_view_t        view,
    input  logic [GTAG_W-1:0]          group,
    output sgc_pkg::cell_upd_t         upd,
    output logic [GTAG_W-1:0]          group_next
);
    import sgc_pkg::*;

    logic hit;
    logic cured;

    assign hit = (view.nb_up    && (roll_up    < spread_thr))
              || (view.nb_down  && (roll_down  < spread_thr))
              || (view.nb_left  && (roll_left  < spread_thr))
              || (view.nb_right && (roll_right < spread_thr));
    assign cured = roll_cure < recover_thr;

    always_comb
    begin
        upd.on     = view.on;
        upd.was_on = view.was_on;
        upd.fixed  = view.fixed;
        group_next = group;
        case (func)
            FUNC_PRESS:
            begin
                case (edit_mode)
                    MODE_TOGGLE:
                    begin
                        upd.on     = ~view.on;
                        upd.was_on = ~view.on;
                    end
                    MODE_FIX:
                    begin
                        // unfixed -> fixed off -> fixed on -> unfixed (stays on)
                        if (!view.fixed)
                        begin
                            upd.fixed = 1'b1;
                            upd.on    = 1'b0;
                        end
                        else if (!view.on)
                        begin
                            upd.on = 1'b1;
                        end
                        else
                        begin
                            upd.fixed = 1'b0;
                        end
                    end
                    MODE_GROUP:
                    begin
                        if (group >= GTAG_W'(GROUP_COUNT - 1))
                            group_next = '0;
                        else
                            group_next = group + 1'b1;
                    end
                    default:
                    begin
                        upd.on = view.on;
                    end
                endcase
            end
            FUNC_STEP:
            begin
                if (gate_high)
                    upd.on = 1'b1;
                if (!view.was_on)
                begin
                    if (hit && !view.fixed)
                        upd.on = 1'b1;
                end
                else if (cured && !view.fixed)
                begin
                    upd.on = 1'b0;
                end
            end
            default:
            begin
                upd.on = view.on;
            end
        endcase
    end

endmodule

// ===== sv/sgc_group_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_group_reduce
// Gate word and per-group OR / AND of the current cell states.
// ----------------------------------------------------------------------------
module sgc_group_reduce #(
    parameter int CELL_COUNT  = 16,
    parameter int GROUP_COUNT = sgc_pkg::GROUP_COUNT_DEF,
    parameter int GTAG_W      = 2
) (
    input  logic [CELL_COUNT-1:0]             cell_on,
    input  logic [CELL_COUNT-1:0][GTAG_W-1:0] cell_group,
    output logic [sgc_pkg::GATES_W-1:0]       gates,
    output logic [sgc_pkg::GRP_OUT_W-1:0]     group_any,
    output logic [sgc_pkg::GRP_OUT_W-1:0]     group_all
);
    import sgc_pkg::*;

    generate
        if (CELL_COUNT >= GATES_W)
        begin : g_gates_trunc
            assign gates = cell_on[GATES_W-1:0];
        end
        else
        begin : g_gates_ext
            assign gates = GATES_W'(cell_on);
        end
    endgenerate

    genvar g;
    generate
        for (g = 0; g < GRP_OUT_W; g++)
        begin : g_grp
            if (g < GROUP_COUNT)
            begin : g_live
                logic any_on;
                logic any_off;
                always_comb
                begin
                    any_on  = 1'b0;
                    any_off = 1'b0;
                    for (int i = 0; i < CELL_COUNT; i++)
                    begin
                        if (cell_group[i] == GTAG_W'(g))
                        begin
                            any_on  = any_on  | cell_on[i];
                            any_off = any_off | ~cell_on[i];
                        end
                    end
                end
                assign group_any[g] = any_on;
                assign group_all[g] = ~any_off;
            end
            else
            begin : g_empty
                // group never used: no members
                assign group_any[g] = 1'b0;
                assign group_all[g] = 1'b1;
            end
        end
    endgenerate

endmodule

// ===== sv/stochastic_grid_contagion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stochastic_grid_contagion
// Grid of on/off cells with supplied-roll spread and recovery, gate generator.
// ----------------------------------------------------------------------------
// Accepts one item per clock while no commit is held back. Each beat is
// captured in the input register and handled there by a single pass of logic
// that reads the addressed cell and its four neighbors and writes that cell
// back; a commit beat lands in the output register, from which its result is
// presented. Press and step beats return nothing. A commit waits in the
// input register only while the output register holds an untaken result.
// Configuration writes are taken at once and must be made while the block is
// idle.
module stochastic_grid_contagion #(
    parameter int GRID_SIDE   = sgc_pkg::GRID_SIDE_DEF,
    parameter int GROUP_COUNT = sgc_pkg::GROUP_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sgc_pkg::FUNC_W-1:0]     func,
    input  logic [sgc_pkg::IDX_W-1:0]      cell_index,
    input  logic                           gate_high,
    input  logic [sgc_pkg::ROLL_W-1:0]     roll_up,
    input  logic [sgc_pkg::ROLL_W-1:0]     roll_down,
    input  logic [sgc_pkg::ROLL_W-1:0]     roll_left,
    input  logic [sgc_pkg::ROLL_W-1:0]     roll_right,
    input  logic [sgc_pkg::ROLL_W-1:0]     roll_cure,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sgc_pkg::GATES_W-1:0]    gates,
    output logic [sgc_pkg::GRP_OUT_W-1:0]  group_any,
    output logic [sgc_pkg::GRP_OUT_W-1:0]  group_all,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sgc_pkg::*;

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int CIDX_W     = $clog2(CELL_COUNT);
    localparam int GTAG_W     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int CMP_W      = 10;

    // configuration
    logic [THR_W-1:0]  spread_thr_reg;
    logic [THR_W-1:0]  recover_thr_reg;
    logic [MODE_W-1:0] edit_mode_reg;

    // input register
    logic              s1_valid_reg;
    logic [FUNC_W-1:0] s1_func_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_gate_reg;
    logic [ROLL_W-1:0] s1_up_reg;
    logic [ROLL_W-1:0] s1_down_reg;
    logic [ROLL_W-1:0] s1_left_reg;
    logic [ROLL_W-1:0] s1_right_reg;
    logic [ROLL_W-1:0] s1_cure_reg;

    // cell state
    logic [CELL_COUNT-1:0]             on_reg;
    logic [CELL_COUNT-1:0]             was_on_reg;
    logic [CELL_COUNT-1:0]             fixed_reg;
    logic [CELL_COUNT-1:0][GTAG_W-1:0] group_reg;

    // output register
    logic                 out_valid_reg;
    logic [GATES_W-1:0]   gates_reg;
    logic [GRP_OUT_W-1:0] any_reg;
    logic [GRP_OUT_W-1:0] all_reg;

    logic                  s1_adv;
    logic                  is_commit;
    logic                  is_edit;
    logic [CMP_W-1:0]      idx_w;
    logic                  in_grid;
    logic                  up_ok;
    logic                  down_ok;
    logic [CIDX_W-1:0]     cidx;
    logic [CIDX_W-1:0]     up_idx;
    logic [CIDX_W-1:0]     down_idx;
    logic [CIDX_W-1:0]     left_idx;
    logic [CIDX_W-1:0]     right_idx;
    logic [CELL_COUNT-1:0] has_left;
    logic [CELL_COUNT-1:0] has_right;
    cell_view_t            view;
    cell_upd_t             upd;
    logic [GTAG_W-1:0]     group_next;
    logic [GATES_W-1:0]    gates_next;
    logic [GRP_OUT_W-1:0]  any_next;
    logic [GRP_OUT_W-1:0]  all_next;

    assign is_commit = s1_func_reg == FUNC_COMMIT;
    assign is_edit   = (s1_func_reg == FUNC_PRESS) || (s1_func_reg == FUNC_STEP);
    assign s1_adv    = s1_valid_reg && (!is_commit || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign cfg_ready = 1'b1;

    // column edges, fixed per cell
    genvar k;
    generate
        for (k = 0; k < CELL_COUNT; k++)
        begin : g_edge
            assign has_left[k]  = (k % GRID_SIDE) != 0;
            assign has_right[k] = (k % GRID_SIDE) != (GRID_SIDE - 1);
        end
    endgenerate

    assign idx_w     = CMP_W'(s1_idx_reg);
    assign in_grid   = idx_w < CMP_W'(CELL_COUNT);
    assign up_ok     = idx_w >= CMP_W'(GRID_SIDE);
    assign down_ok   = (idx_w + CMP_W'(GRID_SIDE)) < CMP_W'(CELL_COUNT);
    assign cidx      = CIDX_W'(s1_idx_reg);
    assign up_idx    = cidx - CIDX_W'(GRID_SIDE);
    assign down_idx  = cidx + CIDX_W'(GRID_SIDE);
    assign left_idx  = cidx - 1'b1;
    assign right_idx = cidx + 1'b1;

    // out-of-grid neighbor reads are masked by their ok terms
    always_comb
    begin
        view.on       = in_grid && on_reg[cidx];
        view.was_on   = in_grid && was_on_reg[cidx];
        view.fixed    = in_grid && fixed_reg[cidx];
        view.nb_up    = in_grid && up_ok && was_on_reg[up_idx];
        view.nb_down  = in_grid && down_ok && was_on_reg[down_idx];
        view.nb_left  = in_grid && has_left[cidx] && was_on_reg[left_idx];
        view.nb_right = in_grid && has_right[cidx] && was_on_reg[right_idx];
    end

    sgc_cell_update #(
        .GROUP_COUNT (GROUP_COUNT),
        .GTAG_W      (GTAG_W)
    ) u_cell (
        .func        (s1_func_reg),
        .edit_mode   (edit_mode_reg),
        .spread_thr  (spread_thr_reg),
        .recover_thr (recover_thr_reg),
        .gate_high   (s1_gate_reg),
        .roll_up     (s1_up_reg),
        .roll_down   (s1_down_reg),
        .roll_left   (s1_left_reg),
        .roll_right  (s1_right_reg),
        .roll_cure   (s1_cure_reg),
        .view        (view),
        .group       (group_reg[cidx]),
        .upd         (upd),
        .group_next  (group_next)
    );

    sgc_group_reduce #(
        .CELL_COUNT  (CELL_COUNT),
        .GROUP_COUNT (GROUP_COUNT),
        .GTAG_W      (GTAG_W)
    ) u_reduce (
        .cell_on     (on_reg),
        .cell_group  (group_reg),
        .gates       (gates_next),
        .group_any   (any_next),
        .group_all   (all_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_thr_reg  <= SPREAD_RST;
            recover_thr_reg <= RECOVER_RST;
            edit_mode_reg   <= MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPREAD:  spread_thr_reg  <= THR_W'(cfg_data);
                CFG_RECOVER: recover_thr_reg <= THR_W'(cfg_data);
                CFG_MODE:    edit_mode_reg   <= cfg_data[MODE_W-1:0];
                default:     edit_mode_reg   <= edit_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_func_reg  <= func;
            s1_idx_reg   <= cell_index;
            s1_gate_reg  <= gate_high;
            s1_up_reg    <= roll_up;
            s1_down_reg  <= roll_down;
            s1_left_reg  <= roll_left;
            s1_right_reg <= roll_right;
            s1_cure_reg  <= roll_cure;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg     <= '0;
            was_on_reg <= '0;
            fixed_reg  <= '0;
            group_reg  <= '0;
        end
        else if (s1_adv)
        begin
            if (is_commit)
            begin
                was_on_reg <= on_reg;
            end
            else if (is_edit && in_grid)
            begin
                on_reg[cidx]     <= upd.on;
                was_on_reg[cidx] <= upd.was_on;
                fixed_reg[cidx]  <= upd.fixed;
                group_reg[cidx]  <= group_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && is_commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && is_commit)
        begin
            gates_reg <= gates_next;
            any_reg   <= any_next;
            all_reg   <= all_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign gates     = gates_reg;
    assign group_any = any_reg;
    assign group_all = all_reg;

endmodule

// ===== tb/stochastic_grid_contagion_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stochastic_grid_contagion_tb
// Self-checking bench for the grid contagion gate generator.
// ----------------------------------------------------------------------------
// A short directed table covers resets, grid edges, spread, recovery, forced
// gates, fix and group editing and the unused codes. It is followed by about
// 2000 random beats under changing thresholds and press modes. A local grid
// model predicts every commit word that the table does not type in. Both
// sides stall at random in two of the three idling profiles; the third never idles.
module stochastic_grid_contagion_tb;
    import sgc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int SIDE           = GRID_SIDE_DEF;
    localparam int CELLS          = SIDE * SIDE;
    localparam int ROLL_MAX       = 99;
    localparam int THR_MAX        = 100;
    localparam int SETTLE_CYCLES  = 5;
    localparam int TAIL_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int CHUNKS         = 6;
    localparam int CHUNK_ITEMS    = 111;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  cell_no;
        logic              gate;
        logic [ROLL_W-1:0] up;
        logic [ROLL_W-1:0] down;
        logic [ROLL_W-1:0] left;
        logic [ROLL_W-1:0] right;
        logic [ROLL_W-1:0] cure;
    } grid_item_t;

    typedef struct packed {
        logic [GATES_W-1:0]   gates;
        logic [GRP_OUT_W-1:0] any_on;
        logic [GRP_OUT_W-1:0] all_on;
    } gate_word_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        grid_item_t        item;
        logic              pinned;
        gate_word_t        word;
    } grid_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [FUNC_W-1:0]     func;
    logic [IDX_W-1:0]      cell_index;
    logic                  gate_high;
    logic [ROLL_W-1:0]     roll_up;
    logic [ROLL_W-1:0]     roll_down;
    logic [ROLL_W-1:0]     roll_left;
    logic [ROLL_W-1:0]     roll_right;
    logic [ROLL_W-1:0]     roll_cure;
    logic                  out_valid;
    logic                  out_ready;
    logic [GATES_W-1:0]    gates;
    logic [GRP_OUT_W-1:0]  group_any;
    logic [GRP_OUT_W-1:0]  group_all;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // grid model
    logic [CELLS-1:0]  on_now;
    logic [CELLS-1:0]  on_prev;
    logic [CELLS-1:0]  fixed;
    logic [1:0]        group_tag [CELLS];
    logic [THR_W-1:0]  spread_thr;
    logic [THR_W-1:0]  recover_thr;
    logic [MODE_W-1:0] press_mode;

    gate_word_t pending_words [$];
    grid_row_t  directed_rows [$];

    // typed-in expectation that rides along with the current input beat
    logic       pinned_now;
    gate_word_t pinned_word;

    int send_idle_pct;
    int rcv_idle_pct;
    int errors;
    int items_taken;
    int results_checked;
    int reg_writes;
    int quiet_cycles;

    stochastic_grid_contagion dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .cell_index (cell_index),
        .gate_high  (gate_high),
        .roll_up    (roll_up),
        .roll_down  (roll_down),
        .roll_left  (roll_left),
        .roll_right (roll_right),
        .roll_cure  (roll_cure),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .gates      (gates),
        .group_any  (group_any),
        .group_all  (group_all),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic advance_grid(input grid_item_t it, output logic produced,
                                output gate_word_t word);
        int c;
        int row;
        int col;
        logic hit;
        logic [GROUP_COUNT_DEF-1:0] not_all;
        produced = 1'b0;
        word     = '0;
        c        = int'(it.cell_no);
        row      = c / SIDE;
        col      = c % SIDE;
        hit      = 1'b0;
        not_all  = '0;
        case (it.func)
            FUNC_COMMIT:
            begin
                produced = 1'b1;
                for (int i = 0; i < CELLS; i++)
                begin
                    on_prev[i] = on_now[i];
                    if (on_now[i])
                    begin
                        word.gates[i]               = 1'b1;
                        word.any_on[group_tag[i]]   = 1'b1;
                    end
                    else
                        not_all[group_tag[i]] = 1'b1;
                end
                word.all_on = ~not_all;
            end
            FUNC_PRESS:
            begin
                case (press_mode)
                    MODE_TOGGLE:
                    begin
                        on_now[c]  = ~on_now[c];
                        on_prev[c] = on_now[c];
                    end
                    MODE_FIX:
                    begin
                        // unfixed -> fixed off -> fixed on -> unfixed (still on)
                        if (!fixed[c])
                        begin
                            fixed[c]  = 1'b1;
                            on_now[c] = 1'b0;
                        end
                        else if (!on_now[c])
                            on_now[c] = 1'b1;
                        else
                            fixed[c] = 1'b0;
                    end
                    MODE_GROUP:
                        group_tag[c] = group_tag[c] + 2'd1;  // wraps at four groups
                    default: ;
                endcase
            end
            FUNC_STEP:
            begin
                if (it.gate)
                    on_now[c] = 1'b1;
                if (!on_prev[c])
                begin
                    if (row > 0 && on_prev[c - SIDE] && it.up < spread_thr)
                        hit = 1'b1;
                    if (row < SIDE - 1 && on_prev[c + SIDE] && it.down < spread_thr)
                        hit = 1'b1;
                    if (col > 0 && on_prev[c - 1] && it.left < spread_thr)
                        hit = 1'b1;
                    if (col < SIDE - 1 && on_prev[c + 1] && it.right < spread_thr)
                        hit = 1'b1;
                    if (hit && !fixed[c])
                        on_now[c] = 1'b1;
                end
                else if (it.cure < recover_thr && !fixed[c])
                    on_now[c] = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input logic [GATES_W-1:0] want,
                               input logic [GATES_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        grid_item_t seen;
        logic       produced;
        gate_word_t predicted;
        gate_word_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SPREAD:  spread_thr  = cfg_data[THR_W-1:0];
                    CFG_RECOVER: recover_thr = cfg_data[THR_W-1:0];
                    CFG_MODE:    press_mode  = cfg_data[MODE_W-1:0];
                    default: ;
                endcase
                reg_writes++;
            end
            if (in_valid && in_ready)
            begin
                seen = {func, cell_index, gate_high, roll_up, roll_down,
                        roll_left, roll_right, roll_cure};
                advance_grid(seen, produced, predicted);
                items_taken++;
                if (produced)
                    pending_words.push_back(pinned_now ? pinned_word : predicted);
            end
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_words.size() == 0)
                begin
                    $display("%0t: result beat with nothing pending: gates %h any %h all %h",
                             $time, gates, group_any, group_all);
                    errors++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    check_field("gates", want.gates, gates);
                    check_field("group_any", GATES_W'(want.any_on), GATES_W'(group_any));
                    check_field("group_all", GATES_W'(want.all_on), GATES_W'(group_all));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** stochastic_grid_contagion: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);

    // all drive tasks are entered right after a falling edge
    task automatic drive_item(input grid_item_t it, input logic pin, input gate_word_t word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {func, cell_index, gate_high, roll_up, roll_down, roll_left, roll_right,
         roll_cure} <= it;
        pinned_now  <= pin;
        pinned_word <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [THR_W-1:0] spread, input logic [THR_W-1:0] recover,
                            input logic [MODE_W-1:0] mode);
        drain();
        // press and step beats may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
        put_reg(CFG_SPREAD, CFG_DATA_W'(spread));
        put_reg(CFG_RECOVER, CFG_DATA_W'(recover));
        put_reg(CFG_MODE, CFG_DATA_W'(mode));
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic grid_row_t dir_row(input logic [MODE_W-1:0] mode,
                                          input logic [FUNC_W-1:0] fn, input int cell_no,
                                          input logic gate, input int up, input int down,
                                          input int left, input int right, input int cure,
                                          input logic pin, input gate_word_t word);
        grid_row_t r;
        r.mode         = mode;
        r.item.func    = fn;
        r.item.cell_no = IDX_W'(cell_no);
        r.item.gate    = gate;
        r.item.up      = ROLL_W'(up);
        r.item.down    = ROLL_W'(down);
        r.item.left    = ROLL_W'(left);
        r.item.right   = ROLL_W'(right);
        r.item.cure    = ROLL_W'(cure);
        r.pinned       = pin;
        r.word         = word;
        return r;
    endfunction

    initial
    begin
        grid_row_t  r;
        grid_item_t it;
        int         pick;
        int         spread_v;
        int         recover_v;
        logic [MODE_W-1:0] mode_v;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_PRESS;
        cell_index  = '0;
        gate_high   = 1'b0;
        roll_up     = '0;
        roll_down   = '0;
        roll_left   = '0;
        roll_right  = '0;
        roll_cure   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SPREAD;
        cfg_data    = '0;
        pinned_now  = 1'b0;
        pinned_word = '0;

        on_now      = '0;
        on_prev     = '0;
        fixed       = '0;
        for (int i = 0; i < CELLS; i++)
            group_tag[i] = 2'd0;
        spread_thr  = SPREAD_RST;
        recover_thr = RECOVER_RST;
        press_mode  = MODE_RST;

        errors          = 0;
        items_taken     = 0;
        results_checked = 0;
        reg_writes      = 0;
        send_idle_pct   = 31;
        rcv_idle_pct    = 66;

        // reset contents: everything off, all cells in group zero
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_COMMIT, 0, 1'b0, 0, 0, 0, 0, 0,
                                        1'b1, {16'h0000, 4'h0, 4'hE}));
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_PRESS, 0, 1'b0, ROLL_MAX, ROLL_MAX,
                                        ROLL_MAX, ROLL_MAX, ROLL_MAX, 1'b0, '0));
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_PRESS, 15, 1'b0, ROLL_MAX, ROLL_MAX,
                                        ROLL_MAX, ROLL_MAX, ROLL_MAX, 1'b0, '0));
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_COMMIT, 0, 1'b0, 0, 0, 0, 0, 0,
                                        1'b1, {16'h8001, 4'h1, 4'hE}));
        // bottom and top edges: rolls pointing off the grid must not wrap around, then spread and cure
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_STEP, 12, 1'b0, ROLL_MAX, 0,
                                        ROLL_MAX, ROLL_MAX, ROLL_MAX, 1'b0, '0));
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_STEP, 3, 1'b0, 0, ROLL_MAX,
                                        ROLL_MAX, 0, ROLL_MAX, 1'b0, '0));
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_STEP, 1, 1'b0, ROLL_MAX, ROLL_MAX,
                                        0, ROLL_MAX, ROLL_MAX, 1'b0, '0));
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_STEP, 0, 1'b0, ROLL_MAX, ROLL_MAX,
                                        ROLL_MAX, ROLL_MAX, 0, 1'b0, '0));
        // gate forces on, then the cure roll knocks it back off
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_STEP, 15, 1'b1, ROLL_MAX, ROLL_MAX,
                                        ROLL_MAX, ROLL_MAX, 0, 1'b0, '0));
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_COMMIT, 0, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        // roll equal to threshold does not spread
        directed_rows.push_back(dir_row(MODE_TOGGLE, FUNC_STEP, 5, 1'b0, SPREAD_RST, ROLL_MAX,
                                        ROLL_MAX, ROLL_MAX, ROLL_MAX, 1'b0, '0));
        directed_rows.push_back(dir_row(MODE_FIX, FUNC_PRESS, 5, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(MODE_FIX, FUNC_STEP, 5, 1'b1, ROLL_MAX, ROLL_MAX,
                                        ROLL_MAX, ROLL_MAX, ROLL_MAX, 1'b0, '0));
        for (int i = 0; i < 3; i++)
            directed_rows.push_back(dir_row(MODE_FIX, FUNC_PRESS, 6, 1'b0, 0, 0, 0, 0, 0,
                                            1'b0, '0));
        // fixed cell ignores spread from its lit neighbor
        directed_rows.push_back(dir_row(MODE_FIX, FUNC_PRESS, 2, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(MODE_FIX, FUNC_STEP, 2, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(MODE_GROUP, FUNC_PRESS, 0, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(MODE_GROUP, FUNC_PRESS, 1, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(MODE_GROUP, FUNC_PRESS, 1, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(MODE_UNUSED, FUNC_PRESS, 7, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(MODE_UNUSED, FUNC_NONE, 7, 1'b1, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(MODE_UNUSED, FUNC_COMMIT, 0, 1'b0, 0, 0, 0, 0, 0,
                                        1'b0, '0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.mode != press_mode)
                set_regs(spread_thr, recover_thr, r.mode);
            drive_item(r.item, r.pinned, r.word);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 66 : 0;
            rcv_idle_pct  = (ph == 0) ? 66 : (ph == 1) ? 31 : 0;
            for (int ck = 0; ck < CHUNKS; ck++)
            begin
                spread_v  = (ph == 0 && ck == 0) ? 0 :
                            (ph == 0 && ck == 1) ? THR_MAX : $urandom_range(THR_MAX);
                recover_v = (ph == 0 && ck == 0) ? THR_MAX :
                            (ph == 0 && ck == 1) ? 0 : $urandom_range(THR_MAX);
                if (ck < 3)
                    mode_v = MODE_W'(ck);
                else if ($urandom_range(9) == 0)
                    mode_v = MODE_UNUSED;
                else
                    mode_v = MODE_W'($urandom_range(2));
                set_regs(THR_W'(spread_v), THR_W'(recover_v), mode_v);
                for (int k = 0; k < CHUNK_ITEMS; k++)
                begin
                    if (ck == 2 && k == CHUNK_ITEMS / 2)
                        drain();
                    pick = $urandom_range(99);
                    if (pick < 25)
                        it.func = FUNC_PRESS;
                    else if (pick < 78)
                        it.func = FUNC_STEP;
                    else if (pick < 95)
                        it.func = FUNC_COMMIT;
                    else
                        it.func = FUNC_NONE;
                    it.cell_no = IDX_W'($urandom_range(CELLS - 1));
                    it.gate    = ($urandom_range(3) == 0);
                    it.up      = ROLL_W'($urandom_range(ROLL_MAX));
                    it.down    = ROLL_W'($urandom_range(ROLL_MAX));
                    it.left    = ROLL_W'($urandom_range(ROLL_MAX));
                    it.right   = ROLL_W'($urandom_range(ROLL_MAX));
                    it.cure    = ROLL_W'($urandom_range(ROLL_MAX));
                    drive_item(it, 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d item beats and checked %0d gate words over %0d register writes,",
                 items_taken, results_checked, reg_writes);
        $display("with threshold extremes, all press modes and three stall profiles.");
        if (errors == 0 && pending_words.size() == 0)
            $display("** stochastic_grid_contagion: PASSED **");
        else
            $display("** stochastic_grid_contagion: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sgc_pkg.sv
sv/sgc_cell_update.sv
sv/sgc_group_reduce.sv
sv/stochastic_grid_contagion.sv
tb/stochastic_grid_contagion_tb.sv
